### hw/rtl/i2a_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the integer to ascii formatter
// no dependencies

package i2a_pkg;

    // conversion codes
    localparam logic [1:0] CONV_UDEC = 2'd0;
    localparam logic [1:0] CONV_SDEC = 2'd1;
    localparam logic [1:0] CONV_HEX  = 2'd2;

    // ascii codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPA   = 7'h41;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;

    // reciprocal of ten, scaled by 2^35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  conversion;
        logic [5:0]  field_width;
        logic        zero_pad;
        logic        left_align;
    } in_item_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } out_item_t;

    // one digit step of the shared divider
    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  rem;
    } div_res_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_UPA + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

### hw/rtl/i2a_div_unit.sv
`timescale 1ns / 1ps
// shared digit unit: divides by ten through a registered reciprocal multiply, or by sixteen combinationally
// depends on i2a_pkg

module i2a_div_unit import i2a_pkg::*; (
    input  logic        aclk,
    input  logic        mul_en,
    input  logic        base_hex,
    input  logic [31:0] operand,
    output div_res_t    result
);

    logic [63:0] product;
    logic [31:0] quot_reg;
    logic [3:0]  q_times_ten_lo;

    // quotient estimate by reciprocal multiply, registered
    assign product = 64'(operand) * 64'(RECIP_TEN);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            quot_reg <= 32'(product[63:RECIP_SHIFT]);
        end
    end

    // low nibble of q*10 = q*8 + q*2 is enough since the remainder is below ten
    assign q_times_ten_lo = {quot_reg[0], 3'b000} + {quot_reg[2:0], 1'b0};

    always_comb begin
        if (base_hex) begin
            result.quot = {4'h0, operand[31:4]};
            result.rem  = operand[3:0];
        end else begin
            result.quot = quot_reg;
            result.rem  = operand[3:0] - q_times_ten_lo;
        end
    end

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// integer to ascii field formatter, top level
// depends on i2a_pkg and i2a_div_unit
//
// usage:
//   s_ channel takes one item: value, conversion kind, field width and the
//   zero-pad / left-justify flags. m_ channel returns the characters of the
//   formatted field one per transfer, in order, with last set on the final one.
//   the block takes one item at a time: s_ready is high only while idle.
// sequence per item (receiver never stalling):
//   the transfer, then digit generation, least significant first, through
//   one shared divide unit: a reciprocal multiply step, then a remainder
//   step per decimal digit or a single step per hex digit; then a field
//   layout step, then one character per cycle.
// the output register decouples the sides: a new item is taken while the
// last character of the previous field still waits for m_ready.
// a stalled receiver holds the current character and stops the sequencer in emission.
// reset (aresetn low, synchronous) returns to idle and drops m_valid.
// field_width above MAX_FIELD_WIDTH is clipped to it.

module integer_to_ascii_formatter import i2a_pkg::*; #(
    parameter int unsigned MAX_FIELD_WIDTH = 63
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SUB  = 5'b00100,
        ST_PREP = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t      state_reg, state_next;

    // operand and item attributes
    logic [31:0] val_reg, val_next;
    logic        hex_reg, hex_next;
    logic        neg_reg, neg_next;
    logic        zpad_reg, zpad_next;
    logic        left_reg, left_next;
    logic [5:0]  width_reg, width_next;

    // digit store, least significant first
    logic [3:0]  digit_mem [16];
    logic        digit_we;
    logic [3:0]  nd_reg, nd_next;
    logic [3:0]  dig_ptr_reg, dig_ptr_next;

    // field layout boundaries
    logic [5:0]  b_sign_reg, b_sign_next;
    logic [5:0]  b_zero_reg, b_zero_next;
    logic [5:0]  b_dig_reg, b_dig_next;
    logic [5:0]  b_rpad_reg, b_rpad_next;
    logic [5:0]  total_reg, total_next;
    logic [5:0]  pos_reg, pos_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    // shared divide unit
    div_res_t    div_res;
    logic        mul_en;
    logic [3:0]  cur_digit;

    // layout scratch
    logic [5:0]  width_sat;
    logic [5:0]  len;
    logic [5:0]  pad;
    logic        load_out;
    logic        is_last;

    i2a_div_unit u_div (
        .aclk     (aclk),
        .mul_en   (mul_en),
        .base_hex (hex_reg),
        .operand  (val_reg),
        .result   (div_res)
    );

    assign width_sat = (s_item.field_width > 6'(MAX_FIELD_WIDTH)) ?
                       6'(MAX_FIELD_WIDTH) : s_item.field_width;
    assign len = {2'b00, nd_reg} + {5'b00000, neg_reg};
    assign pad = (width_reg > len) ? (width_reg - len) : 6'd0;

    assign s_ready   = (state_reg == ST_IDLE);
    assign mul_en    = (state_reg == ST_DIV) && !hex_reg;
    assign cur_digit = digit_mem[dig_ptr_reg];
    assign load_out  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign is_last   = (pos_reg == total_reg - 6'd1);

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        hex_next     = hex_reg;
        neg_next     = neg_reg;
        zpad_next    = zpad_reg;
        left_next    = left_reg;
        width_next   = width_reg;
        nd_next      = nd_reg;
        dig_ptr_next = dig_ptr_reg;
        b_sign_next  = b_sign_reg;
        b_zero_next  = b_zero_reg;
        b_dig_next   = b_dig_reg;
        b_rpad_next  = b_rpad_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        digit_we     = 1'b0;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        // receiver took the held character
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    hex_next   = s_item.conversion[1];
                    neg_next   = (s_item.conversion == CONV_SDEC) && s_item.value[31];
                    val_next   = neg_next ? (32'd0 - s_item.value) : s_item.value;
                    zpad_next  = s_item.zero_pad;
                    left_next  = s_item.left_align;
                    width_next = width_sat;
                    nd_next    = 4'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (hex_reg) begin
                    // hex digit is ready at once
                    digit_we = 1'b1;
                    val_next = div_res.quot;
                    nd_next  = nd_reg + 4'd1;
                    if (div_res.quot == 32'd0) begin
                        state_next = ST_PREP;
                    end
                end else begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                digit_we = 1'b1;
                val_next = div_res.quot;
                nd_next  = nd_reg + 4'd1;
                state_next = (div_res.quot == 32'd0) ? ST_PREP : ST_DIV;
            end
            ST_PREP: begin
                // leading spaces, sign, zeros, digits, trailing spaces
                b_sign_next  = (!left_reg && !zpad_reg) ? pad : 6'd0;
                b_zero_next  = b_sign_next + {5'b00000, neg_reg};
                b_dig_next   = b_zero_next + ((!left_reg && zpad_reg) ? pad : 6'd0);
                b_rpad_next  = b_dig_next + {2'b00, nd_reg};
                total_next   = b_rpad_next + (left_reg ? pad : 6'd0);
                pos_next     = 6'd0;
                dig_ptr_next = nd_reg - 4'd1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_item_next.last = is_last;
                    if (pos_reg < b_sign_reg) begin
                        m_item_next.character = CH_SPACE;
                    end else if (pos_reg < b_zero_reg) begin
                        m_item_next.character = CH_MINUS;
                    end else if (pos_reg < b_dig_reg) begin
                        m_item_next.character = CH_ZERO;
                    end else if (pos_reg < b_rpad_reg) begin
                        m_item_next.character = digit_char(cur_digit);
                        dig_ptr_next = dig_ptr_reg - 4'd1;
                    end else begin
                        m_item_next.character = CH_SPACE;
                    end
                    pos_next = pos_reg + 6'd1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        hex_reg     <= hex_next;
        neg_reg     <= neg_next;
        zpad_reg    <= zpad_next;
        left_reg    <= left_next;
        width_reg   <= width_next;
        nd_reg      <= nd_next;
        dig_ptr_reg <= dig_ptr_next;
        b_sign_reg  <= b_sign_next;
        b_zero_reg  <= b_zero_next;
        b_dig_reg   <= b_dig_next;
        b_rpad_reg  <= b_rpad_next;
        total_reg   <= total_next;
        pos_reg     <= pos_next;
        m_item_reg  <= m_item_next;
    end

    // digit store
    always_ff @(posedge aclk) begin
        if (digit_we) begin
            digit_mem[nd_reg] <= div_res.rem;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // checks

    // sequencer stays one-hot
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state register not one-hot");

    // at most ten decimal digits of a 32-bit value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |-> (nd_reg >= 4'd1 && nd_reg <= 4'd10))
        else $error("digit count out of range");

    // emission never runs past the field
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pos_reg < total_reg))
        else $error("character position past end of field");

    // digit reads stay inside the written digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && pos_reg >= b_dig_reg && pos_reg < b_rpad_reg) |->
            (dig_ptr_reg < nd_reg))
        else $error("digit read outside stored digits");

endmodule

### tb/sv/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// self-checking testbench for integer_to_ascii_formatter: a directed table, then random fields
// every accepted item is turned into its expected characters, which are compared with each m_ transfer
// depends on i2a_pkg and the formatter rtl

module tb_integer_to_ascii_formatter import i2a_pkg::*; ();

    localparam int MAX_W           = 63;
    localparam int RANDOM_ITEMS    = 450;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the block
    localparam int STALL_LIMIT     = 4000;  // cycles with no transfer on either side
    localparam int FLUSH_CYCLES    = 80;    // quiet time at the end, after all fields are done
    localparam int REPORT_LIMIT    = 10;

    // code 3 has no name in the package, it behaves as hex
    localparam logic [1:0] CONV_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // characters still owed by the block, oldest first
    out_item_t expected_chars[$];

    // scratch field built by the predictor or by a typed table row
    logic [6:0] field_chars [0:63];
    int         field_len;

    // directed table: an empty text means the predictor supplies the field
    in_item_t table_items[$];
    string    table_texts[$];

    int fail_count     = 0;
    int chars_checked  = 0;
    int items_sent     = 0;
    int negative_items = 0;
    int hex_items      = 0;
    int wide_fields    = 0;
    int hold_off_asked = 0;

    integer_to_ascii_formatter #(
        .MAX_FIELD_WIDTH(MAX_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    // builds the characters of one formatted field into field_chars / field_len
    function automatic void format_field(input in_item_t it);
        logic [6:0]  digit_buf [0:15];
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] r;
        bit          hex;
        bit          neg;
        int          width;
        int          nd;
        int          pad;
        int          p;
        hex   = it.conversion[1];
        base  = hex ? 32'd16 : 32'd10;
        width = int'(it.field_width);
        if (width > MAX_W) begin
            width = MAX_W;
        end
        // sign only matters for signed decimal
        neg = !hex && (it.conversion == CONV_SDEC) && it.value[31];
        mag = neg ? 32'd0 - it.value : it.value;
        nd  = 0;
        if (mag == 32'd0) begin
            digit_buf[0] = CH_ZERO;
            nd = 1;
        end else begin
            // least significant digit first
            while (mag != 32'd0) begin
                r = mag % base;
                digit_buf[nd] = (r < 32'd10) ? CH_ZERO + r[6:0] : CH_UPA + r[6:0] - 7'd10;
                mag = mag / base;
                nd++;
            end
        end
        pad = width - nd - (neg ? 1 : 0);
        if (pad < 0) begin
            pad = 0;
        end
        field_len = 0;
        // right-justified spaces go ahead of the sign
        if (!it.left_align && !it.zero_pad) begin
            for (p = 0; p < pad; p++) begin
                field_chars[field_len++] = CH_SPACE;
            end
        end
        if (neg) begin
            field_chars[field_len++] = CH_MINUS;
        end
        // zero padding sits between sign and digits
        if (!it.left_align && it.zero_pad) begin
            for (p = 0; p < pad; p++) begin
                field_chars[field_len++] = CH_ZERO;
            end
        end
        for (p = nd - 1; p >= 0; p--) begin
            field_chars[field_len++] = digit_buf[p];
        end
        // left justification always pads with trailing spaces
        if (it.left_align) begin
            for (p = 0; p < pad; p++) begin
                field_chars[field_len++] = CH_SPACE;
            end
        end
    endfunction

    task automatic table_row(input logic [31:0] value, input logic [1:0] conv,
                             input logic [5:0] width, input logic zpad, input logic left,
                             input string text);
        in_item_t it;
        it.value       = value;
        it.conversion  = conv;
        it.field_width = width;
        it.zero_pad    = zpad;
        it.left_align  = left;
        table_items.push_back(it);
        table_texts.push_back(text);
    endtask

    // offers one item, waits for its transfer, then queues the characters it owes
    task automatic send_item(input in_item_t it, input string text);
        out_item_t ch;
        byte       b;
        int        i;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (text.len() == 0) begin
            format_field(it);
        end else begin
            field_len = text.len();
            for (i = 0; i < field_len; i++) begin
                b = text[i];
                field_chars[i] = b[6:0];
            end
        end
        for (i = 0; i < field_len; i++) begin
            ch.character = field_chars[i];
            ch.last      = (i == field_len - 1);
            expected_chars.push_back(ch);
        end
        items_sent++;
        if (it.conversion == CONV_SDEC && it.value[31]) begin
            negative_items++;
        end
        if (it.conversion[1]) begin
            hex_items++;
        end
        if (field_len > 20) begin
            wide_fields++;
        end
    endtask

    // valid drops right after a transfer, so it never goes low and high in one step
    task automatic sender_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // sender pause until the block has returned every owed character
    task automatic wait_fields_done();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int          k;
        int          e;
        case ($urandom_range(0, 9)) inside
            [0:3]: v = $urandom;
            4:     v = $urandom_range(0, 20);
            5: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            6: v = 32'd0 - $urandom_range(1, 1000);   // small negatives
            7: begin
                // powers of ten and their neighbors, where digit counts change
                e = $urandom_range(0, 9);
                v = 32'd1;
                for (k = 0; k < e; k++) begin
                    v = v * 32'd10;
                end
                v = v - $urandom_range(0, 1);
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic in_item_t pick_item();
        in_item_t it;
        it.value       = pick_value();
        it.conversion  = 2'($urandom_range(0, 3));
        // mostly short fields, a tenth reach toward the maximum
        it.field_width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(15, 63))
                                                     : 6'($urandom_range(0, 14));
        it.zero_pad    = 1'($urandom_range(0, 1));
        it.left_align  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // receiver: changes stall pattern every so often, and serves long hold-off requests
    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       hold_left;
        int       served;
        mode      = RX_STEADY;
        span      = 0;
        hold_left = 0;
        served    = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_asked != served) begin
                served    = hold_off_asked;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 200);
                end
                span--;
                case (mode)
                    RX_STEADY: m_ready <= 1'b1;
                    RX_LIGHT:  m_ready <= ($urandom_range(0, 9) < 7);
                    RX_HEAVY:  m_ready <= ($urandom_range(0, 9) < 2);
                    default:   m_ready <= (span % 5 != 0);
                endcase
            end
        end
    end

    // result check: every m_ transfer against the oldest owed character
    always @(posedge aclk) begin : check_output
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected transfer: char 0x%02h last %0b",
                             m_item.character, m_item.last);
                end
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_item.character !== want.character || m_item.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("char %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
                                 chars_checked, want.character, want.last,
                                 m_item.character, m_item.last);
                    end
                end
            end
        end
    end

    // watchdog: too long with no transfer on either side ends the run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_integer_to_ascii_formatter NOT OK");
        $finish;
    end

    initial begin : stimulus
        int r;
        int k;
        int burst;
        int sent_random;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;

        // extremes, every conversion, sign and padding placement
        table_row(32'h0000_0000, CONV_UDEC,  6'd0,  1'b0, 1'b0, "0");
        table_row(32'hFFFF_FFFF, CONV_UDEC,  6'd0,  1'b0, 1'b0, "4294967295");
        table_row(32'h8000_0000, CONV_SDEC,  6'd0,  1'b0, 1'b0, "-2147483648");
        table_row(32'hFFFF_FFFF, CONV_SDEC,  6'd0,  1'b0, 1'b0, "-1");
        table_row(32'h7FFF_FFFF, CONV_SDEC,  6'd0,  1'b0, 1'b0, "2147483647");
        table_row(32'h8000_0000, CONV_UDEC,  6'd0,  1'b0, 1'b0, "2147483648");
        table_row(32'hFFFF_FFFF, CONV_HEX,   6'd0,  1'b0, 1'b0, "FFFFFFFF");
        table_row(32'h0000_0000, CONV_HEX,   6'd0,  1'b0, 1'b0, "0");
        // unused conversion code acts as hex, signedness ignored
        table_row(32'h1234_ABCD, CONV_SPARE, 6'd0,  1'b0, 1'b0, "1234ABCD");
        table_row(32'h8000_0000, CONV_SPARE, 6'd9,  1'b1, 1'b0, "080000000");
        // minus five: zeros after the sign, spaces before it, left pads with spaces
        table_row(32'hFFFF_FFFB, CONV_SDEC,  6'd5,  1'b1, 1'b0, "-0005");
        table_row(32'hFFFF_FFFB, CONV_SDEC,  6'd5,  1'b0, 1'b0, "   -5");
        table_row(32'hFFFF_FFFB, CONV_SDEC,  6'd5,  1'b1, 1'b1, "-5   ");
        table_row(32'h0000_002A, CONV_UDEC,  6'd6,  1'b0, 1'b1, "42    ");
        // digits wider than the field, nothing cut, then zero padding cases
        table_row(32'd123456,    CONV_UDEC,  6'd3,  1'b1, 1'b0, "123456");
        table_row(32'h0000_BEEF, CONV_HEX,   6'd10, 1'b1, 1'b0, "000000BEEF");
        table_row(32'h0000_0000, CONV_SDEC,  6'd1,  1'b1, 1'b0, "0");
        table_row(32'd9,         CONV_UDEC,  6'd2,  1'b1, 1'b0, "09");
        table_row(32'hFFFF_FF9C, CONV_SDEC,  6'd0,  1'b0, 1'b0, "-100");
        // wide fields, left to the predictor
        table_row(32'd7,         CONV_UDEC,  6'd63, 1'b0, 1'b0, "");
        table_row(32'h8000_0000, CONV_SDEC,  6'd63, 1'b1, 1'b0, "");
        table_row(32'hFFFF_FFFF, CONV_HEX,   6'd63, 1'b0, 1'b1, "");
        table_row(32'h0000_0000, CONV_UDEC,  6'd63, 1'b1, 1'b1, "");
        table_row(32'h7FFF_FFFF, CONV_SPARE, 6'd42, 1'b1, 1'b1, "");

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < table_items.size(); r++) begin
            send_item(table_items[r], table_texts[r]);
            if ($urandom_range(0, 2) == 0) begin
                sender_gap($urandom_range(1, 5));
            end
        end
        wait_fields_done();

        // random part: bursts of items with random gaps between them
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent_random < RANDOM_ITEMS; k++) begin
                // receiver holds off while the sender keeps offering items
                if (sent_random == 150 || sent_random == 380) begin
                    hold_off_asked <= hold_off_asked + 1;
                end
                if (sent_random == 300) begin
                    wait_fields_done();
                end
                send_item(pick_item(), "");
                sent_random++;
            end
            if ($urandom_range(0, 3) != 0) begin
                sender_gap($urandom_range(1, 8));
            end
        end

        wait_fields_done();
        repeat (FLUSH_CYCLES) @(posedge aclk);
        fail_count += expected_chars.size();

        $display("formatted %0d fields into %0d characters: %0d negative, %0d hex,",
                 items_sent, chars_checked, negative_items, hex_items);
        $display("%0d of them wider than 20 characters", wide_fields);
        if (fail_count == 0) begin
            $display("tb_integer_to_ascii_formatter OK");
        end else begin
            $display("tb_integer_to_ascii_formatter NOT OK");
        end
        $finish;
    end

endmodule

### integer_to_ascii_formatter.f
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_div_unit.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/sv/tb_integer_to_ascii_formatter.sv
